FILE: rtl/scc_pkg.sv
// ============================================================================
// scc_pkg - stick command conditioner shared definitions
// Types, constants and register indexes used by the conditioner modules.
// ============================================================================
package scc_pkg;

    // Stick reading width: default and the widest supported value
    localparam int STICK_BITS_DEF = 12;
    localparam int STICK_BITS_MAX = 16;

    // Signed deviation width, wide enough for the widest stick
    localparam int DEV_W  = STICK_BITS_MAX + 1;
    // Product of a deviation and a 16-bit unsigned full scale
    localparam int PROD_W = 2 * DEV_W;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TILT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YAW    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_STEP   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_CNT = 4'd3;

    // Register reset values
    localparam logic [14:0] MAX_TILT_RST   = 15'd5120;
    localparam logic [15:0] MAX_YAW_RST    = 16'd23040;
    localparam logic [10:0] ALT_STEP_RST   = 11'd16;
    localparam logic [7:0]  TOGGLE_CNT_RST = 8'd3;

    // Deadzone bounds (exclusive) and throttle thresholds
    localparam logic [DEV_W-1:0] ROLL_DZ_LO  = 17'd2050;
    localparam logic [DEV_W-1:0] ROLL_DZ_HI  = 17'd2150;
    localparam logic [DEV_W-1:0] PITCH_DZ_LO = 17'd2000;
    localparam logic [DEV_W-1:0] PITCH_DZ_HI = 17'd2100;
    localparam logic [DEV_W-1:0] YAW_DZ_LO   = 17'd1000;
    localparam logic [DEV_W-1:0] YAW_DZ_HI   = 17'd3000;
    localparam logic [DEV_W-1:0] CLIMB_DOWN_TH = 17'd2000;
    localparam logic [DEV_W-1:0] CLIMB_UP_TH   = 17'd2200;

    // Altitude store
    localparam logic [14:0] ALT_RST = 15'd800;
    localparam logic [14:0] ALT_MAX = 15'd19200;

    // Mismatch counter saturation
    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        CLIMB_HOLD = 2'd0,
        CLIMB_DOWN = 2'd1,
        CLIMB_UP   = 2'd2
    } t_climb;

    // Classified packet handed from front to back
    typedef struct packed {
        logic signed [DEV_W-1:0] roll_dev;
        logic signed [DEV_W-1:0] pitch_dev;
        logic signed [DEV_W-1:0] yaw_dev;
        t_climb                  climb;
        logic                    want_on;
    } t_item;

    // Configuration register set
    typedef struct packed {
        logic [14:0] max_tilt;
        logic [15:0] max_yaw;
        logic [10:0] alt_step;
        logic [7:0]  toggle_cnt;
    } t_cfg;

    // Queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: rtl/scc_front.sv
// ============================================================================
// scc_front - packet classifier
// Applies stick deadzones, forms signed deviations, classifies the throttle
// and the start word, and pushes the result into the queue.
// ============================================================================
module scc_front #(
    parameter int STICK_BITS = scc_pkg::STICK_BITS_DEF
) (
    input  logic                  i_valid,
    input  logic [STICK_BITS-1:0] i_stick_roll,
    input  logic [STICK_BITS-1:0] i_stick_pitch,
    input  logic [STICK_BITS-1:0] i_stick_climb,
    input  logic [STICK_BITS-1:0] i_stick_yaw,
    input  logic [15:0]           i_start_word,
    input  scc_pkg::t_q_stat      i_q_stat,
    output logic                  o_stall,
    output logic                  o_push,
    output scc_pkg::t_item        o_item
);

    localparam logic [scc_pkg::DEV_W-1:0] CENTRE =
        scc_pkg::DEV_W'(1) << (STICK_BITS - 1);

    logic [scc_pkg::DEV_W-1:0] roll_ext;
    logic [scc_pkg::DEV_W-1:0] pitch_ext;
    logic [scc_pkg::DEV_W-1:0] climb_ext;
    logic [scc_pkg::DEV_W-1:0] yaw_ext;
    logic roll_dz;
    logic pitch_dz;
    logic yaw_dz;

    assign roll_ext  = scc_pkg::DEV_W'(i_stick_roll);
    assign pitch_ext = scc_pkg::DEV_W'(i_stick_pitch);
    assign climb_ext = scc_pkg::DEV_W'(i_stick_climb);
    assign yaw_ext   = scc_pkg::DEV_W'(i_stick_yaw);

    assign roll_dz  = (roll_ext > scc_pkg::ROLL_DZ_LO) && (roll_ext < scc_pkg::ROLL_DZ_HI);
    assign pitch_dz = (pitch_ext > scc_pkg::PITCH_DZ_LO) &&
                      (pitch_ext < scc_pkg::PITCH_DZ_HI);
    assign yaw_dz   = (yaw_ext > scc_pkg::YAW_DZ_LO) && (yaw_ext < scc_pkg::YAW_DZ_HI);

    always_comb begin
        // Snap to centre inside a deadzone, which is a zero deviation
        o_item.roll_dev  = roll_dz  ? '0 : signed'(CENTRE - roll_ext);
        o_item.pitch_dev = pitch_dz ? '0 : signed'(pitch_ext - CENTRE);
        o_item.yaw_dev   = yaw_dz   ? '0 : signed'(yaw_ext - CENTRE);
        if (climb_ext < scc_pkg::CLIMB_DOWN_TH) begin
            o_item.climb = scc_pkg::CLIMB_DOWN;
        end else if (climb_ext > scc_pkg::CLIMB_UP_TH) begin
            o_item.climb = scc_pkg::CLIMB_UP;
        end else begin
            o_item.climb = scc_pkg::CLIMB_HOLD;
        end
        o_item.want_on = (i_start_word != 16'd0);
    end

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

endmodule

FILE: rtl/scc_queue.sv
// ============================================================================
// scc_queue - two-entry item queue
// Decouples the classifier from the executing back end.
// ============================================================================
module scc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  scc_pkg::t_item   i_item,
    input  logic             i_pop,
    output scc_pkg::t_item   o_item,
    output scc_pkg::t_q_stat o_stat
);

    localparam logic [1:0] DEPTH = 2'd2;

    scc_pkg::t_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == DEPTH);
    assign o_stat.empty = (r_count == 2'd0);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH)
        else $error("queue count exceeds depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 2'd1)
        else $error("push did not grow queue");
`endif

endmodule

FILE: rtl/scc_back.sv
// ============================================================================
// scc_back - target generator
// Scales deviations to angle targets, updates altitude and power state, and
// holds the result in the output register.
// ============================================================================
module scc_back #(
    parameter int STICK_BITS = scc_pkg::STICK_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scc_pkg::t_cfg       i_cfg,
    input  scc_pkg::t_item      i_item,
    input  scc_pkg::t_q_stat    i_q_stat,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic signed [15:0]  o_roll_target,
    output logic signed [15:0]  o_pitch_target,
    output logic signed [16:0]  o_yaw_target,
    output logic [14:0]         o_altitude_target,
    output logic                o_power_on
);

    localparam int SHIFT = STICK_BITS - 1;

    logic        r_out_valid;
    logic [14:0] r_alt;
    logic        r_on_flag;
    logic [7:0]  r_mismatch;
    logic [14:0] n_alt;
    logic        n_on_flag;
    logic [7:0]  n_mismatch;

    logic signed [scc_pkg::PROD_W-1:0] tilt_s;
    logic signed [scc_pkg::PROD_W-1:0] yaw_s;
    logic signed [scc_pkg::PROD_W-1:0] roll_p;
    logic signed [scc_pkg::PROD_W-1:0] pitch_p;
    logic signed [scc_pkg::PROD_W-1:0] yaw_p;
    logic signed [scc_pkg::PROD_W-1:0] roll_q;
    logic signed [scc_pkg::PROD_W-1:0] pitch_q;
    logic signed [scc_pkg::PROD_W-1:0] yaw_q;
    logic [15:0] alt_up;

    // Take the next item when the output register is free or being taken
    assign o_pop = !i_q_stat.empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        tilt_s  = signed'({{(scc_pkg::PROD_W-15){1'b0}}, i_cfg.max_tilt});
        yaw_s   = signed'({{(scc_pkg::PROD_W-16){1'b0}}, i_cfg.max_yaw});
        roll_p  = scc_pkg::PROD_W'(i_item.roll_dev) * tilt_s;
        pitch_p = scc_pkg::PROD_W'(i_item.pitch_dev) * tilt_s;
        yaw_p   = scc_pkg::PROD_W'(i_item.yaw_dev) * yaw_s;
        // Arithmetic shift floors toward minus infinity
        roll_q  = roll_p >>> SHIFT;
        pitch_q = pitch_p >>> SHIFT;
        yaw_q   = yaw_p >>> SHIFT;
    end

    always_comb begin
        alt_up = {1'b0, r_alt} + 16'(i_cfg.alt_step);
        n_alt  = r_alt;
        case (i_item.climb)
            scc_pkg::CLIMB_DOWN: begin
                n_alt = (r_alt < 15'(i_cfg.alt_step)) ? 15'd0 : r_alt - 15'(i_cfg.alt_step);
            end
            scc_pkg::CLIMB_UP: begin
                n_alt = (alt_up > 16'(scc_pkg::ALT_MAX)) ? scc_pkg::ALT_MAX : alt_up[14:0];
            end
            default: begin
                n_alt = r_alt;
            end
        endcase
    end

    always_comb begin
        if (i_item.want_on != r_on_flag) begin
            n_mismatch = (r_mismatch == scc_pkg::COUNT_MAX) ? r_mismatch : r_mismatch + 8'd1;
        end else begin
            n_mismatch = 8'd0;
        end
        n_on_flag = (n_mismatch >= i_cfg.toggle_cnt) ? !r_on_flag : r_on_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_alt       <= scc_pkg::ALT_RST;
            r_on_flag   <= 1'b0;
            r_mismatch  <= 8'd0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_alt       <= n_alt;
                r_on_flag   <= n_on_flag;
                r_mismatch  <= n_mismatch;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_roll_target  <= roll_q[15:0];
            o_pitch_target <= pitch_q[15:0];
            o_yaw_target   <= yaw_q[16:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_altitude_target = r_alt;
    assign o_power_on        = r_on_flag;

`ifndef NO_ASSERTIONS
    a_alt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alt <= scc_pkg::ALT_MAX)
        else $error("altitude target above limit");

    a_flag_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> $stable(r_on_flag) && $stable(r_alt))
        else $error("state changed without a transaction");

    a_match_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_item.want_on == r_on_flag)) |=> r_mismatch == 8'd0)
        else $error("mismatch count not cleared on agreement");
`endif

endmodule

FILE: rtl/stick_command_conditioner.sv
// ============================================================================
// stick_command_conditioner - remote-control packet to flight targets
// Deadzones and scales roll, pitch and yaw sticks to angle targets, moves a
// stored altitude target with the throttle, and debounces the power flag.
// ============================================================================
//
//  Channel   Direction  Handshake                    Payload
//  --------  ---------  ---------------------------  -------------------------------
//  packet    in         i_in_valid / o_in_stall      four sticks, start word
//  targets   out        o_out_valid / i_out_stall    roll, pitch, yaw, altitude, power
//  config    in         i_cfg_valid / o_cfg_ready    register index, write data
//
//  One packet per cycle sustained while the queue is not full and the output
//  is not stalled. An accepted packet lands in a queue slot; the back end then
//  scales it and updates its state combinationally and loads the result into
//  its output register, which drives the target channel.
//  The two-entry queue between classifier and back end absorbs a stall on the
//  output; o_in_stall rises only when the queue is full.
//  Reset is synchronous and active low; there is no clearing pass, the block
//  accepts a packet as soon as reset is released. Config writes are always
//  ready.
//
module stick_command_conditioner #(
    parameter int STICK_BITS = scc_pkg::STICK_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // packet channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [STICK_BITS-1:0]          i_stick_roll,
    input  logic [STICK_BITS-1:0]          i_stick_pitch,
    input  logic [STICK_BITS-1:0]          i_stick_climb,
    input  logic [STICK_BITS-1:0]          i_stick_yaw,
    input  logic [15:0]                    i_start_word,
    // target channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [15:0]             o_roll_target,
    output logic signed [15:0]             o_pitch_target,
    output logic signed [16:0]             o_yaw_target,
    output logic [14:0]                    o_altitude_target,
    output logic                           o_power_on,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [scc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    scc_pkg::t_cfg    r_cfg;
    scc_pkg::t_cfg    n_cfg;
    scc_pkg::t_item   front_item;
    scc_pkg::t_item   q_item;
    scc_pkg::t_q_stat q_stat;
    logic             push;
    logic             pop;

    // Register file: decode the index, ignore writes beyond the list
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                scc_pkg::CFG_MAX_TILT:   n_cfg.max_tilt   = i_cfg_data[14:0];
                scc_pkg::CFG_MAX_YAW:    n_cfg.max_yaw    = i_cfg_data[15:0];
                scc_pkg::CFG_ALT_STEP:   n_cfg.alt_step   = i_cfg_data[10:0];
                scc_pkg::CFG_TOGGLE_CNT: n_cfg.toggle_cnt = i_cfg_data[7:0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_tilt   <= scc_pkg::MAX_TILT_RST;
            r_cfg.max_yaw    <= scc_pkg::MAX_YAW_RST;
            r_cfg.alt_step   <= scc_pkg::ALT_STEP_RST;
            r_cfg.toggle_cnt <= scc_pkg::TOGGLE_CNT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front: classify the packet and push it
    scc_front #(
        .STICK_BITS (STICK_BITS)
    ) u_front (
        .i_valid       (i_in_valid),
        .i_stick_roll  (i_stick_roll),
        .i_stick_pitch (i_stick_pitch),
        .i_stick_climb (i_stick_climb),
        .i_stick_yaw   (i_stick_yaw),
        .i_start_word  (i_start_word),
        .i_q_stat      (q_stat),
        .o_stall       (o_in_stall),
        .o_push        (push),
        .o_item        (front_item)
    );

    // Queue: hold classified packets between front and back
    scc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // Back: scale, advance altitude and power state, register the result
    scc_back #(
        .STICK_BITS (STICK_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_item            (q_item),
        .i_q_stat          (q_stat),
        .o_pop             (pop),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_roll_target     (o_roll_target),
        .o_pitch_target    (o_pitch_target),
        .o_yaw_target      (o_yaw_target),
        .o_altitude_target (o_altitude_target),
        .o_power_on        (o_power_on)
    );

endmodule

FILE: dv/scc_target_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_target_checker - flight target predictor and comparator
// Watches the packet, target and config channels of the stick command
// conditioner. Keeps its own copy of the registers and of the altitude and
// power state. Queues the expected targets per accepted packet and compares
// each accepted target transaction field by field.
// ----------------------------------------------------------------------------
module scc_target_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [11:0]                    i_stick_roll,
    input  logic [11:0]                    i_stick_pitch,
    input  logic [11:0]                    i_stick_climb,
    input  logic [11:0]                    i_stick_yaw,
    input  logic [15:0]                    i_start_word,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic signed [15:0]             i_roll_target,
    input  logic signed [15:0]             i_pitch_target,
    input  logic signed [16:0]             i_yaw_target,
    input  logic [14:0]                    i_altitude_target,
    input  logic                           i_power_on,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [scc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_toggles
);

    localparam int CENTRE = 2048;

    typedef struct {
        logic signed [15:0] roll_target;
        logic signed [15:0] pitch_target;
        logic signed [16:0] yaw_target;
        logic [14:0]        altitude_target;
        logic               power_on;
    } t_targets;

    t_targets    expected_targets [$];

    logic [14:0] tilt_scale;
    logic [15:0] yaw_scale;
    logic [10:0] alt_step;
    logic [7:0]  toggle_need;
    logic [14:0] altitude_q4;
    logic        power_flag;
    logic [7:0]  miss_run;

    // floor(dev * full / 2048); arithmetic shift of a signed longint floors
    function automatic longint scale_floor(input longint dev, input longint full);
        return (dev * full) >>> 11;
    endfunction

    function automatic t_targets predict_targets(
        input logic [11:0] roll,
        input logic [11:0] pitch,
        input logic [11:0] climb,
        input logic [11:0] yaw,
        input logic [15:0] start
    );
        t_targets t;
        int       r;
        int       p;
        int       y;
        int       alt;
        logic     want_on;
        r = roll;
        p = pitch;
        y = yaw;
        // snap readings inside the deadzones to centre
        if (r > scc_pkg::ROLL_DZ_LO && r < scc_pkg::ROLL_DZ_HI) r = CENTRE;
        if (p > scc_pkg::PITCH_DZ_LO && p < scc_pkg::PITCH_DZ_HI) p = CENTRE;
        if (y > scc_pkg::YAW_DZ_LO && y < scc_pkg::YAW_DZ_HI) y = CENTRE;

        alt = altitude_q4;
        if (climb < scc_pkg::CLIMB_DOWN_TH) begin
            alt = alt - alt_step;
            if (alt < 0) alt = 0;
        end else if (climb > scc_pkg::CLIMB_UP_TH) begin
            alt = alt + alt_step;
            if (alt > scc_pkg::ALT_MAX) alt = scc_pkg::ALT_MAX;
        end
        altitude_q4 = 15'(alt);

        // debounce the power request; counter survives the toggle
        want_on = (start != 16'd0);
        if (want_on != power_flag) begin
            if (miss_run < scc_pkg::COUNT_MAX) miss_run = miss_run + 8'd1;
        end else begin
            miss_run = 8'd0;
        end
        if (miss_run >= toggle_need) begin
            power_flag = !power_flag;
            o_toggles++;
        end

        t.roll_target     = 16'(scale_floor(CENTRE - r, tilt_scale));
        t.pitch_target    = 16'(scale_floor(p - CENTRE, tilt_scale));
        t.yaw_target      = 17'(scale_floor(y - CENTRE, yaw_scale));
        t.altitude_target = altitude_q4;
        t.power_on        = power_flag;
        return t;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_toggles    = 0;
    end

    always @(posedge i_clk) begin
        t_targets want;
        if (!i_rst_n) begin
            tilt_scale  = scc_pkg::MAX_TILT_RST;
            yaw_scale   = scc_pkg::MAX_YAW_RST;
            alt_step    = scc_pkg::ALT_STEP_RST;
            toggle_need = scc_pkg::TOGGLE_CNT_RST;
            altitude_q4 = scc_pkg::ALT_RST;
            power_flag  = 1'b0;
            miss_run    = 8'd0;
            expected_targets.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    scc_pkg::CFG_MAX_TILT:   tilt_scale  = i_cfg_data[14:0];
                    scc_pkg::CFG_MAX_YAW:    yaw_scale   = i_cfg_data;
                    scc_pkg::CFG_ALT_STEP:   alt_step    = i_cfg_data[10:0];
                    scc_pkg::CFG_TOGGLE_CNT: toggle_need = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // retire the target transaction before queuing a new packet
            if (i_out_valid && !i_out_stall) begin
                if (expected_targets.size() == 0) begin
                    $display("%0t: target transaction with none expected, expected none, actual roll %0d",
                             $time, i_roll_target);
                    o_fail_count++;
                end else begin
                    want = expected_targets.pop_front();
                    check_field("roll_target", want.roll_target, i_roll_target);
                    check_field("pitch_target", want.pitch_target, i_pitch_target);
                    check_field("yaw_target", want.yaw_target, i_yaw_target);
                    check_field("altitude_target", want.altitude_target, i_altitude_target);
                    check_field("power_on", want.power_on, i_power_on);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_targets.push_back(predict_targets(i_stick_roll, i_stick_pitch,
                                                           i_stick_climb, i_stick_yaw,
                                                           i_start_word));
            end
        end
        o_pending = expected_targets.size();
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - stick command conditioner testbench
// Drives directed and random remote-control packets through several register
// settings with random idle and stall cycles; a separate checker predicts and
// compares the flight targets, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    // Cycles with no transaction on any channel before the run is abandoned
    localparam int STALL_LIMIT = 2000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [11:0]                    i_stick_roll;
    logic [11:0]                    i_stick_pitch;
    logic [11:0]                    i_stick_climb;
    logic [11:0]                    i_stick_yaw;
    logic [15:0]                    i_start_word;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic signed [15:0]             o_roll_target;
    logic signed [15:0]             o_pitch_target;
    logic signed [16:0]             o_yaw_target;
    logic [14:0]                    o_altitude_target;
    logic                           o_power_on;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [scc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [scc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    int              fail_count;
    int              pending;
    int              checked;
    int              toggles;
    int              packet_count;
    int              setting_count;
    int              idle_cycles;
    logic            calm;          // no idling on either side while set
    int              cur_toggle;    // toggle count last written, shapes power runs
    scc_pkg::t_climb climb_dir;
    int              climb_run;
    logic            power_req;
    int              power_run;

    stick_command_conditioner dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_stick_roll      (i_stick_roll),
        .i_stick_pitch     (i_stick_pitch),
        .i_stick_climb     (i_stick_climb),
        .i_stick_yaw       (i_stick_yaw),
        .i_start_word      (i_start_word),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_roll_target     (o_roll_target),
        .o_pitch_target    (o_pitch_target),
        .o_yaw_target      (o_yaw_target),
        .o_altitude_target (o_altitude_target),
        .o_power_on        (o_power_on),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    scc_target_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_stick_roll      (i_stick_roll),
        .i_stick_pitch     (i_stick_pitch),
        .i_stick_climb     (i_stick_climb),
        .i_stick_yaw       (i_stick_yaw),
        .i_start_word      (i_start_word),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_roll_target     (o_roll_target),
        .i_pitch_target    (o_pitch_target),
        .i_yaw_target      (o_yaw_target),
        .i_altitude_target (o_altitude_target),
        .i_power_on        (o_power_on),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_toggles         (toggles)
    );

    always #5 i_clk = ~i_clk;

    // Receiver side: stall about a quarter of the cycles, never while calm
    always @(negedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 24);
    end

    // Watchdog: abandon the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Entered and left at a falling edge. Idle at random first, then hold the
    // transaction until the block takes it; valid stays high for the caller.
    task automatic send_packet(
        input logic [11:0] roll,
        input logic [11:0] pitch,
        input logic [11:0] climb,
        input logic [11:0] yaw,
        input logic [15:0] start
    );
        while (!calm && $urandom_range(0, 99) < 24) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stick_roll  <= roll;
        i_stick_pitch <= pitch;
        i_stick_climb <= climb;
        i_stick_yaw   <= yaw;
        i_start_word  <= start;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        packet_count++;
    endtask

    // Drop valid and wait until every queued target has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Write all four registers back to back; valid stays high across them
    task automatic write_registers(input int tilt, input int yaw, input int step,
                                   input int toggle);
        logic [scc_pkg::CFG_IDX_W-1:0] idx [4];
        int                            vals [4];
        idx[0] = scc_pkg::CFG_MAX_TILT;
        idx[1] = scc_pkg::CFG_MAX_YAW;
        idx[2] = scc_pkg::CFG_ALT_STEP;
        idx[3] = scc_pkg::CFG_TOGGLE_CNT;
        vals[0] = tilt;
        vals[1] = yaw;
        vals[2] = step;
        vals[3] = toggle;
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < 4; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= scc_pkg::CFG_DATA_W'(vals[k]);
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cur_toggle = toggle;
        setting_count++;
    endtask

    // Stick extremes, deadzone and throttle edges, start word patterns
    task automatic run_directed();
        send_packet(12'd0,    12'd0,    12'd0,    12'd0,    16'hFFFF);
        send_packet(12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF);
        send_packet(12'd2050, 12'd2000, 12'd1999, 12'd1000, 16'h8000);
        send_packet(12'd2051, 12'd2001, 12'd2000, 12'd1001, 16'h0001);
        send_packet(12'd2149, 12'd2099, 12'd2200, 12'd2999, 16'h0000);
        send_packet(12'd2150, 12'd2100, 12'd2201, 12'd3000, 16'h0000);
        send_packet(12'd2048, 12'd2048, 12'd2100, 12'd2048, 16'h0000);
        send_packet(12'd1,    12'd2047, 12'd4095, 12'd4094, 16'h0000);
        send_packet(12'd2049, 12'd2049, 12'd0,    12'd2047, 16'hAAAA);
        send_packet(12'd4094, 12'd1,    12'd1998, 12'd1,    16'h5555);
        send_packet(12'd2100, 12'd2050, 12'd2202, 12'd2000, 16'h0000);
        send_packet(12'd2048, 12'd2048, 12'd2048, 12'd2048, 16'h0000);
    endtask

    // Half the time uniform, else near a deadzone edge or between the deadzone bounds
    function automatic logic [11:0] pick_axis(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0, 1:    return 12'($urandom_range(0, 4095));
            2:       return 12'(($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 4) - 2);
            default: return 12'($urandom_range(lo, hi));
        endcase
    endfunction

    // Throttle moves in runs so the altitude reaches both clamps; the start
    // word holds a request for runs around the toggle count, with a few
    // single-packet glitches that break the run
    task automatic random_packet();
        logic [11:0] climb;
        logic        want;
        logic [15:0] start;
        if (climb_run == 0) begin
            climb_dir = scc_pkg::t_climb'($urandom_range(0, 2));
            climb_run = $urandom_range(1, 20);
        end
        climb_run--;
        if ($urandom_range(0, 99) < 15) begin
            climb = 12'($urandom_range(0, 4095));
        end else begin
            case (climb_dir)
                scc_pkg::CLIMB_DOWN: climb = 12'($urandom_range(0, 1999));
                scc_pkg::CLIMB_UP:   climb = 12'($urandom_range(2201, 4095));
                default:             climb = 12'($urandom_range(2000, 2200));
            endcase
        end
        if (power_run == 0) begin
            power_req = !power_req;
            power_run = $urandom_range(1, cur_toggle + 3);
        end
        power_run--;
        want = power_req ^ ($urandom_range(0, 99) < 8);
        if (!want) begin
            start = 16'h0000;
        end else if ($urandom_range(0, 3) == 0) begin
            start = 16'h0001 << $urandom_range(0, 15);
        end else begin
            start = 16'($urandom_range(1, 65535));
        end
        send_packet(pick_axis(scc_pkg::ROLL_DZ_LO, scc_pkg::ROLL_DZ_HI),
                    pick_axis(scc_pkg::PITCH_DZ_LO, scc_pkg::PITCH_DZ_HI),
                    climb, pick_axis(scc_pkg::YAW_DZ_LO, scc_pkg::YAW_DZ_HI), start);
    endtask

    task automatic run_random(input int count, input logic no_idle);
        calm = no_idle;
        repeat (count) random_packet();
        calm = 1'b0;
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        i_stick_roll  = '0;
        i_stick_pitch = '0;
        i_stick_climb = '0;
        i_stick_yaw   = '0;
        i_start_word  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        calm          = 1'b0;
        cur_toggle    = scc_pkg::TOGGLE_CNT_RST;
        climb_dir     = scc_pkg::CLIMB_HOLD;
        climb_run     = 0;
        power_req     = 1'b0;
        power_run     = 0;
        packet_count  = 0;
        setting_count = 0;
        idle_cycles   = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of the registers
        run_directed();

        // Full scale everywhere, toggle count of one
        settle();
        write_registers(23040, 46080, 1600, 1);
        run_directed();
        run_random(150, 1'b0);

        // Zero scale and step, slowest toggle
        settle();
        write_registers(0, 0, 0, 255);
        run_random(320, 1'b0);

        // Toggle count of zero: flag inverts on every packet
        settle();
        write_registers($urandom_range(0, 23040), $urandom_range(0, 46080),
                        $urandom_range(0, 1600), 0);
        run_random(150, 1'b0);

        // Random settings; the first one runs with no idling at all
        settle();
        write_registers($urandom_range(0, 23040), $urandom_range(0, 46080),
                        $urandom_range(0, 1600), $urandom_range(1, 12));
        run_random(250, 1'b1);

        settle();
        write_registers($urandom_range(0, 23040), $urandom_range(0, 46080),
                        $urandom_range(0, 1600), $urandom_range(1, 8));
        run_random(250, 1'b0);

        settle();
        write_registers($urandom_range(0, 23040), $urandom_range(0, 46080),
                        $urandom_range(1, 400), $urandom_range(1, 255));
        run_random(330, 1'b0);

        // Drain, then give the block time to show any stray transaction
        settle();
        repeat (10) @(negedge i_clk);

        $display("Sent %0d packets across %0d register settings plus reset values.",
                 packet_count, setting_count);
        $display("Checked %0d target transactions, %0d power toggles predicted.",
                 checked, toggles);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: stick_command_conditioner.f
rtl/scc_pkg.sv
rtl/scc_front.sv
rtl/scc_queue.sv
rtl/scc_back.sv
rtl/stick_command_conditioner.sv
dv/scc_target_checker.sv
dv/tb.sv
